/* src/rla_pkg.sv */
// ----------------------------------------------------------------------------
// rla_pkg: shared types and constants for the route lookup block
// Item and result words, queue commands, table entries and register indexes.
// ----------------------------------------------------------------------------
package rla_pkg;

  // action codes carried in an item word
  localparam logic [1:0] ACT_LOAD_ROUTE = 2'd0;
  localparam logic [1:0] ACT_LOAD_ARP   = 2'd1;
  localparam logic [1:0] ACT_LOOKUP     = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARP_COUNT   = 4'd1;

  localparam int ROUTE_CNT_W = 11;
  localparam int ARP_CNT_W   = 5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  slot;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] via_ip;
    logic [7:0]  port;
    logic [47:0] mac_in;
    logic [31:0] dest_ip;
  } item_t;

  typedef struct packed {
    logic        route_found;
    logic [31:0] hop_ip;
    logic [7:0]  out_port;
    logic        mac_found;
    logic [47:0] hop_mac;
  } result_t;

  typedef enum logic [1:0] {
    OP_ROUTE,
    OP_ARP,
    OP_LOOKUP
  } op_t;

  typedef struct packed {
    op_t   op;
    item_t item;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [7:0]  port;
  } route_ent_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } arp_ent_t;

endpackage

/* src/rla_front.sv */
// ----------------------------------------------------------------------------
// rla_front: item intake and classification
// Accepts item words, drops unused actions and out-of-range slots, and turns
// the rest into commands for the queue.
// ----------------------------------------------------------------------------
module rla_front #(
  parameter int ROUTE_SLOTS = 1024,
  parameter int ARP_SLOTS   = 16
) (
  input  logic           item_valid,
  output logic           item_stall,
  input  rla_pkg::item_t item,
  input  logic           q_full,
  output logic           push,
  output rla_pkg::cmd_t  cmd
);
  import rla_pkg::*;

  logic [31:0] slot_ext;
  logic        accept;
  logic        keep;
  op_t         op;

  assign slot_ext   = {22'd0, item.slot};
  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;

  always_comb begin
    keep = 1'b0;
    op   = OP_LOOKUP;
    case (item.action)
      ACT_LOAD_ROUTE: begin
        op   = OP_ROUTE;
        keep = slot_ext < 32'(ROUTE_SLOTS);
      end
      ACT_LOAD_ARP: begin
        op   = OP_ARP;
        keep = slot_ext < 32'(ARP_SLOTS);
      end
      ACT_LOOKUP: begin
        op   = OP_LOOKUP;
        keep = 1'b1;
      end
      default: begin
        op   = OP_LOOKUP;
        keep = 1'b0;
      end
    endcase
  end

  assign push     = accept && keep;
  assign cmd.op   = op;
  assign cmd.item = item;

endmodule

/* src/rla_queue.sv */
// ----------------------------------------------------------------------------
// rla_queue: command queue between front and back
// A short first-in first-out buffer of commands.
// ----------------------------------------------------------------------------
module rla_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rla_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output logic                head_valid,
  output rla_pkg::cmd_t       head,
  output rla_pkg::queue_stat_t stat
);
  import rla_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign stat.empty = count == '0;
  assign head_valid = !stat.empty;
  assign head       = entries[rd_ptr];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/rla_back.sv */
// ----------------------------------------------------------------------------
// rla_back: table storage and lookup engine
// Executes queued commands: writes route and ARP entries, scans the route
// table one slot a cycle for the longest mask, then, if a route was found, scans the ARP table.
// ----------------------------------------------------------------------------
module rla_back #(
  parameter int ROUTE_SLOTS = 1024,
  parameter int ARP_SLOTS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  rla_pkg::cmd_t                       q_cmd,
  output logic                                q_pop,
  input  logic [rla_pkg::ROUTE_CNT_W-1:0]     route_count,
  input  logic [rla_pkg::ARP_CNT_W-1:0]       arp_count,
  output logic                                result_valid,
  input  logic                                result_stall,
  output rla_pkg::result_t                    result
);
  import rla_pkg::*;

  localparam int RIDX_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int RCNT_W = $clog2(ROUTE_SLOTS + 1);
  localparam int AIDX_W = (ARP_SLOTS > 1) ? $clog2(ARP_SLOTS) : 1;
  localparam int ACNT_W = $clog2(ARP_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUTE = 4'b0010,
    S_ARP   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  route_ent_t route_mem [ROUTE_SLOTS];
  arp_ent_t   arp_mem [ARP_SLOTS];

  state_t            state;
  logic [RCNT_W-1:0] ridx;
  logic [ACNT_W-1:0] aidx;
  logic              r_cmp;
  logic              a_cmp;
  route_ent_t        route_rd;
  arp_ent_t          arp_rd;
  logic [31:0]       dest;
  logic              found;
  logic [31:0]       best_mask;
  logic [31:0]       hop;
  logic [7:0]        port;
  logic              mac_found;
  logic [47:0]       mac;
  logic              res_valid;
  result_t           res;

  logic [RCNT_W-1:0] route_used;
  logic [ACNT_W-1:0] arp_used;
  logic [31:0]       slot_ext;
  logic              route_we;
  logic              arp_we;
  logic              r_issue;
  logic              a_issue;
  logic              r_hit;
  logic              a_hit;
  route_ent_t        route_wr;
  arp_ent_t          arp_wr;

  // counts above the table size saturate
  assign route_used = (32'(route_count) > 32'(ROUTE_SLOTS)) ? RCNT_W'(ROUTE_SLOTS)
                                                            : RCNT_W'(route_count);
  assign arp_used   = (32'(arp_count) > 32'(ARP_SLOTS)) ? ACNT_W'(ARP_SLOTS)
                                                        : ACNT_W'(arp_count);

  assign slot_ext = {22'd0, q_cmd.item.slot};
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign route_we = q_pop && (q_cmd.op == OP_ROUTE);
  assign arp_we   = q_pop && (q_cmd.op == OP_ARP);

  assign route_wr.prefix = q_cmd.item.prefix;
  assign route_wr.mask   = q_cmd.item.mask;
  assign route_wr.hop    = q_cmd.item.via_ip;
  assign route_wr.port   = q_cmd.item.port;
  assign arp_wr.ip       = q_cmd.item.via_ip;
  assign arp_wr.mac      = q_cmd.item.mac_in;

  assign r_issue = (state == S_ROUTE) && (ridx < route_used);
  assign a_issue = (state == S_ARP) && (aidx < arp_used) && !mac_found;

  // ties on the mask go to the later slot
  assign r_hit = r_cmp && (((dest ^ route_rd.prefix) & route_rd.mask) == 32'd0)
                 && (!found || (route_rd.mask >= best_mask));
  // first match wins; later reads still in flight are dropped
  assign a_hit = a_cmp && !mac_found && (arp_rd.ip == hop);

  always_ff @(posedge clk) begin
    if (route_we) begin
      route_mem[slot_ext[RIDX_W-1:0]] <= route_wr;
    end
    if (r_issue) begin
      route_rd <= route_mem[ridx[RIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (arp_we) begin
      arp_mem[slot_ext[AIDX_W-1:0]] <= arp_wr;
    end
    if (a_issue) begin
      arp_rd <= arp_mem[aidx[AIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      r_cmp     <= 1'b0;
      a_cmp     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      r_cmp <= r_issue;
      a_cmp <= a_issue;
      // the done state always leaves a word in the output register
      if (!result_stall && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid && (q_cmd.op == OP_LOOKUP)) begin
            state     <= S_ROUTE;
            ridx      <= '0;
            aidx      <= '0;
            found     <= 1'b0;
            best_mask <= 32'd0;
            hop       <= 32'd0;
            port      <= 8'd0;
            mac_found <= 1'b0;
            mac       <= 48'd0;
            dest      <= q_cmd.item.dest_ip;
          end
        end
        S_ROUTE: begin
          if (r_issue) begin
            ridx <= ridx + 1'b1;
          end
          if (r_hit) begin
            found     <= 1'b1;
            best_mask <= route_rd.mask;
            hop       <= route_rd.hop;
            port      <= route_rd.port;
          end
          if (!r_issue && !r_cmp) begin
            state <= found ? S_ARP : S_DONE;
          end
        end
        S_ARP: begin
          if (a_issue) begin
            aidx <= aidx + 1'b1;
          end
          if (a_hit) begin
            mac_found <= 1'b1;
            mac       <= arp_rd.mac;
          end
          if (!a_issue && !a_cmp) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!res_valid || !result_stall) begin
            res_valid       <= 1'b1;
            res.route_found <= found;
            res.hop_ip      <= hop;
            res.out_port    <= port;
            res.mac_found   <= mac_found;
            res.hop_mac     <= mac;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_valid = res_valid;
  assign result       = res;

endmodule

/* src/route_lookup_with_arp_resolve.sv */
// ----------------------------------------------------------------------------
// route_lookup_with_arp_resolve: IPv4 longest-prefix route lookup with ARP
// Route and ARP tables, loaded and searched through one item channel.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall / item): action 0 loads a route
//   entry, action 1 an ARP entry, action 2 looks up dest_ip. Loads give no
//   result. Each lookup gives one word on the result channel (result_valid /
//   result_stall / result) with the best route and its resolved MAC.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) sets
//   route_count and arp_count; write it only while the block is idle.
//   Items pass a four-entry command queue. A load writes its table entry
//   as it leaves the queue; a lookup holds the engine until done, using the
//   single read port of each table: the route table is scanned one slot a
//   cycle, then, if a route was found, the ARP table one slot a cycle,
//   stopping at the first hit. Input stalls only when the queue is full.
//   A finished result waits in an output register while the next command
//   is worked on; a stalled result holds until taken.
//   Reset clears both counts, the queue and the result valid flag. Table
//   contents are undefined until loaded; no clearing pass is made.
// ----------------------------------------------------------------------------
module route_lookup_with_arp_resolve #(
  parameter int ROUTE_SLOTS = 1024,
  parameter int ARP_SLOTS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  rla_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output rla_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rla_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rla_pkg::*;

  logic [ROUTE_CNT_W-1:0] route_count;
  logic [ARP_CNT_W-1:0]   arp_count;
  logic                   q_push;
  cmd_t                   q_in;
  logic                   q_pop;
  logic                   q_valid;
  cmd_t                   q_head;
  queue_stat_t            q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
      arp_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROUTE_COUNT: route_count <= cfg_data[ROUTE_CNT_W-1:0];
        CFG_ARP_COUNT:   arp_count   <= cfg_data[ARP_CNT_W-1:0];
        default:         ;
      endcase
    end
  end

  rla_front #(
    .ROUTE_SLOTS (ROUTE_SLOTS),
    .ARP_SLOTS   (ARP_SLOTS)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_stat.full),
    .push       (q_push),
    .cmd        (q_in)
  );

  rla_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head),
    .stat       (q_stat)
  );

  rla_back #(
    .ROUTE_SLOTS (ROUTE_SLOTS),
    .ARP_SLOTS   (ARP_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_head),
    .q_pop        (q_pop),
    .route_count  (route_count),
    .arp_count    (arp_count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  a_no_route_clears_all: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.route_found |->
      !result.mac_found && result.hop_ip == 32'd0 && result.out_port == 8'd0)
    else $error("route fields set without a matching route");

  a_no_mac_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.mac_found |-> result.hop_mac == 48'd0)
    else $error("hop_mac set without an ARP match");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for route_lookup_with_arp_resolve
// Loads route and ARP entries, runs lookups over several table sizes and
// compares every result word against a scoreboard that keeps its own copy
// of both tables and both count registers.
// ----------------------------------------------------------------------------
import rla_pkg::*;

localparam int ROUTE_DEPTH = 1024;
localparam int ARP_DEPTH   = 16;

class lookup_scoreboard;
  logic [31:0] rt_prefix [ROUTE_DEPTH];
  logic [31:0] rt_mask   [ROUTE_DEPTH];
  logic [31:0] rt_hop    [ROUTE_DEPTH];
  logic [7:0]  rt_port   [ROUTE_DEPTH];
  bit          rt_loaded [ROUTE_DEPTH];
  logic [31:0] arp_ip     [ARP_DEPTH];
  logic [47:0] arp_mac    [ARP_DEPTH];
  bit          arp_loaded [ARP_DEPTH];
  int unsigned route_count;
  int unsigned arp_count;
  result_t     expected_results [$];
  int unsigned bad_count;

  function new();
    route_count = 0;
    arp_count   = 0;
    bad_count   = 0;
    for (int i = 0; i < ROUTE_DEPTH; i++) rt_loaded[i] = 1'b0;
    for (int i = 0; i < ARP_DEPTH; i++) arp_loaded[i] = 1'b0;
  endfunction

  function int unsigned routes_in_use();
    return (route_count > ROUTE_DEPTH) ? ROUTE_DEPTH : route_count;
  endfunction

  function int unsigned arps_in_use();
    return (arp_count > ARP_DEPTH) ? ARP_DEPTH : arp_count;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_ROUTE_COUNT) route_count = {21'd0, val};
    else if (idx == CFG_ARP_COUNT) arp_count = {27'd0, val[ARP_CNT_W-1:0]};
  endfunction

  // longest mask wins, ties go to the highest slot; lowest ARP slot wins
  function result_t resolve_dest(logic [31:0] dest);
    result_t     r;
    logic [31:0] best_mask;
    r = '0;
    best_mask = '0;
    for (int i = 0; i < routes_in_use(); i++) begin
      if (((dest ^ rt_prefix[i]) & rt_mask[i]) == 32'h0 &&
          (!r.route_found || rt_mask[i] >= best_mask)) begin
        r.route_found = 1'b1;
        best_mask     = rt_mask[i];
        r.hop_ip      = rt_hop[i];
        r.out_port    = rt_port[i];
      end
    end
    if (r.route_found) begin
      for (int j = 0; j < arps_in_use(); j++) begin
        if (!r.mac_found && arp_ip[j] == r.hop_ip) begin
          r.mac_found = 1'b1;
          r.hop_mac   = arp_mac[j];
        end
      end
    end
    return r;
  endfunction

  function void note_item(item_t it);
    case (it.action)
      ACT_LOAD_ROUTE: begin
        if (it.slot < ROUTE_DEPTH) begin
          rt_prefix[it.slot] = it.prefix;
          rt_mask[it.slot]   = it.mask;
          rt_hop[it.slot]    = it.via_ip;
          rt_port[it.slot]   = it.port;
          rt_loaded[it.slot] = 1'b1;
        end
      end
      ACT_LOAD_ARP: begin
        if (it.slot < ARP_DEPTH) begin
          arp_ip[it.slot]     = it.via_ip;
          arp_mac[it.slot]    = it.mac_in;
          arp_loaded[it.slot] = 1'b1;
        end
      end
      ACT_LOOKUP: expected_results.push_back(resolve_dest(it.dest_ip));
      default: ;
    endcase
  endfunction

  function void report(string what, result_t want, result_t got);
    bad_count++;
    if (bad_count <= 10) begin
      $write("%0t %s: expected found=%0d hop=%h port=%h mac_found=%0d mac=%h,",
             $time, what, want.route_found, want.hop_ip, want.out_port,
             want.mac_found, want.hop_mac);
      $display(" got found=%0d hop=%h port=%h mac_found=%0d mac=%h",
               got.route_found, got.hop_ip, got.out_port, got.mac_found,
               got.hop_mac);
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report("result word with no lookup pending", '0, got);
    end else begin
      want = expected_results.pop_front();
      if (got.route_found !== want.route_found || got.hop_ip !== want.hop_ip ||
          got.out_port !== want.out_port || got.mac_found !== want.mac_found ||
          got.hop_mac !== want.hop_mac)
        report("lookup result mismatch", want, got);
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_top;
  localparam logic [1:0]           ACT_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BAD = CFG_ARP_COUNT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_IDX  = {CFG_IDX_W{1'b1}};
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT   = 8000;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lookup_scoreboard sb;
  bit               tx_idle_on;
  bit               rx_idle_on;
  logic [31:0]      hop_pool [8];
  logic [31:0]      base_pool [4];
  int unsigned      quiet_cycles;

  route_lookup_with_arp_resolve #(
    .ROUTE_SLOTS(ROUTE_DEPTH),
    .ARP_SLOTS  (ARP_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: check each accepted word, stall in random bursts when rx_idle_on
  initial begin
    int unsigned hold;
    hold = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result);
      if (hold > 0) hold--;
      else if (rx_idle_on && $urandom_range(0, 11) == 0) hold = $urandom_range(1, 17);
      result_stall <= (hold != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t fresh_item(input logic [1:0] act);
    item_t       it;
    logic [63:0] w;
    w = {$urandom, $urandom};
    it.action   = act;
    it.slot     = 10'($urandom_range(0, ROUTE_DEPTH - 1));
    it.prefix   = $urandom;
    it.mask     = $urandom;
    it.via_ip   = $urandom;
    it.port     = 8'($urandom_range(0, 255));
    it.mac_in   = w[47:0];
    it.dest_ip  = $urandom;
    return it;
  endfunction

  task automatic push_item(input item_t it);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  task automatic load_route(input logic [9:0] slot, input logic [31:0] pfx,
                            input logic [31:0] msk, input logic [31:0] hop,
                            input logic [7:0] prt);
    item_t it;
    it = fresh_item(ACT_LOAD_ROUTE);
    it.slot     = slot;
    it.prefix   = pfx;
    it.mask     = msk;
    it.via_ip   = hop;
    it.port     = prt;
    push_item(it);
  endtask

  task automatic load_arp(input logic [9:0] slot, input logic [31:0] ip,
                          input logic [47:0] mac);
    item_t it;
    it = fresh_item(ACT_LOAD_ARP);
    it.slot     = slot;
    it.via_ip   = ip;
    it.mac_in   = mac;
    push_item(it);
  endtask

  task automatic lookup(input logic [31:0] dest);
    item_t it;
    it = fresh_item(ACT_LOOKUP);
    it.dest_ip = dest;
    push_item(it);
  endtask

  // hold off until every lookup has returned and trailing loads are done
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic write_counts(input logic [CFG_DATA_W-1:0] routes,
                              input logic [CFG_DATA_W-1:0] arps, input bit junk);
    drain();
    put_reg(CFG_ROUTE_COUNT, routes);
    put_reg(CFG_ARP_COUNT, arps);
    if (junk) put_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_BAD, CFG_LAST_IDX)),
                      CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] make_mask();
    int len;
    len = $urandom_range(0, 32);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  task automatic load_random_route(input logic [9:0] slot);
    logic [31:0] pfx;
    logic [31:0] hop;
    pfx = ($urandom_range(0, 1) == 0) ? base_pool[$urandom_range(0, 3)] : $urandom;
    hop = ($urandom_range(0, 3) != 0) ? hop_pool[$urandom_range(0, 7)] : $urandom;
    load_route(slot, pfx, make_mask(), hop, 8'($urandom_range(0, 255)));
  endtask

  task automatic load_random_arp(input logic [9:0] slot);
    logic [31:0] ip;
    logic [63:0] w;
    w  = {$urandom, $urandom};
    ip = ($urandom_range(0, 3) != 0) ? hop_pool[$urandom_range(0, 7)] : $urandom;
    load_arp(slot, ip, w[47:0]);
  endtask

  // every slot below a count must hold an entry before a lookup reads it
  task automatic fill_tables();
    for (int s = 0; s < sb.routes_in_use(); s++)
      if (!sb.rt_loaded[s]) load_random_route(10'(s));
    for (int s = 0; s < sb.arps_in_use(); s++)
      if (!sb.arp_loaded[s]) load_random_arp(10'(s));
  endtask

  task automatic random_table_op();
    int unsigned sel;
    int unsigned used;
    int unsigned pick;
    logic [31:0] dest;
    item_t       it;
    sel  = $urandom_range(0, 99);
    used = sb.routes_in_use();
    if (sel < 22) begin
      if (used > 0 && $urandom_range(0, 2) != 0)
        load_random_route(10'($urandom_range(0, used - 1)));
      else load_random_route(10'($urandom_range(0, ROUTE_DEPTH - 1)));
    end else if (sel < 36) begin
      if ($urandom_range(0, 7) != 0) load_random_arp(10'($urandom_range(0, ARP_DEPTH - 1)));
      else load_random_arp(10'($urandom_range(0, ROUTE_DEPTH - 1)));
    end else if (sel < 41) begin
      it = fresh_item(ACT_UNUSED);
      push_item(it);
    end else begin
      // aim most lookups inside a live route, flipping host bits at random
      if (used > 0 && $urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, used - 1);
        dest = (sb.rt_prefix[pick] & sb.rt_mask[pick]) | ($urandom & ~sb.rt_mask[pick]);
        if ($urandom_range(0, 5) == 0) dest[$urandom_range(0, 31)] ^= 1'b1;
      end else begin
        dest = $urandom;
      end
      lookup(dest);
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] routes,
                           input logic [CFG_DATA_W-1:0] arps,
                           input bit tx_idle, input bit rx_idle, input int count);
    write_counts(routes, arps, 1'($urandom_range(0, 1)));
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    fill_tables();
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) drain();
      random_table_op();
    end
  endtask

  task automatic run_directed();
    item_t it;
    lookup(32'hFFFF_FFFF);
    it = fresh_item(ACT_UNUSED);
    push_item(it);
    load_route(10'd0, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 8'h01);
    load_route(10'd1, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 8'h02);
    // host bits set in the prefix, same mask as slot 1: the higher slot wins
    load_route(10'd2, 32'h0A01_FFFF, 32'hFFFF_0000, 32'h0A01_01FE, 8'hFF);
    load_route(10'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
    load_route(10'd4, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_01FE, 8'h7F);
    load_route(10'd5, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h80);
    load_route(10'd1023, $urandom, make_mask(), $urandom, 8'hFF);
    load_arp(10'd0, 32'h0A00_00FE, 48'h0);
    load_arp(10'd1, 32'h0A01_01FE, 48'hFFFF_FFFF_FFFF);
    load_arp(10'd2, 32'h0A01_01FE, 48'h0123_4567_89AB);
    load_arp(10'd3, 32'hFFFF_FFFF, 48'hA5A5_5A5A_A5A5);
    load_arp(10'd15, 32'h0000_0000, 48'hFEDC_BA98_7654);
    load_arp(10'd1023, 32'hC0A8_01FE, 48'h1111_2222_3333);
    // default route kept out of range first
    write_counts(11'd5, 11'd4, 1'b0);
    lookup(32'h0A01_0203);
    lookup(32'h0A02_0001);
    lookup(32'hFFFF_FFFF);
    lookup(32'hC0A8_0142);
    lookup(32'h0102_0304);
    write_counts(11'd6, 11'd4, 1'b0);
    lookup(32'h0102_0304);
    lookup(32'h0000_0000);
  endtask

  initial begin
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    item         <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    quiet_cycles <= 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    sb = new();
    for (int i = 0; i < 8; i++) hop_pool[i] = $urandom;
    for (int i = 0; i < 4; i++) base_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_counts(11'd0, 11'd0, 1'b1);
    run_directed();
    run_phase(11'd4, 11'd16, 1'b1, 1'b1, 60);
    run_phase(11'd1, 11'd1, 1'b1, 1'b0, 55);
    run_phase(11'd37, 11'd5, 1'b0, 1'b1, 60);
    run_phase(11'd0, 11'd16, 1'b1, 1'b1, 40);
    run_phase(11'd12, 11'd31, 1'b1, 1'b1, 60);
    // ARP count above table size (2047 truncates to 31 in the register): saturate to the full table
    run_phase(11'd30, 11'h7FF, 1'b1, 1'b1, 16);
    run_phase(11'd120, 11'd0, 1'b1, 1'b1, 55);
    run_phase(11'd9, 11'd16, 1'b0, 1'b0, 80);
    drain();
    if (sb.bad_count == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

/* sim.f */
src/rla_pkg.sv
src/rla_front.sv
src/rla_queue.sv
src/rla_back.sv
src/route_lookup_with_arp_resolve.sv
verif/tb_top.sv
